// ===== rtl/core/afc_pkg.sv =====
// Shared types and constants for the box frustum clip status pipeline.
// Used by every module under rtl/core; depends on nothing else.
package afc_pkg;

	// Coefficient rows: four signed Q4.12 lanes of 16 bits each.
	localparam int LANE_BITS  = 16;
	localparam int NUM_LANES  = 4;
	localparam int NUM_ROWS   = 4;
	localparam int NUM_AXES   = 3;
	localparam int NUM_CORNERS = 8;
	localparam int OUTCODE_BITS = 6;

	// Lane order inside a row.
	localparam int LANE_X     = 0;
	localparam int LANE_Y     = 1;
	localparam int LANE_Z     = 2;
	localparam int LANE_CONST = 3;

	// Row order: clip x, y, z, w.
	localparam int ROW_X = 0;
	localparam int ROW_Y = 1;
	localparam int ROW_Z = 2;
	localparam int ROW_W = 3;

	typedef logic [NUM_LANES-1:0][LANE_BITS-1:0] coeff_row_t;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = NUM_LANES * LANE_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_X = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_Y = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_Z = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLIP_W = 2'd3;

	// Reset matrix is the identity (1.0 is 0x1000 in Q4.12).
	localparam coeff_row_t ROW_X_RESET = 64'h0000_0000_0000_1000;
	localparam coeff_row_t ROW_Y_RESET = 64'h0000_0000_1000_0000;
	localparam coeff_row_t ROW_Z_RESET = 64'h0000_1000_0000_0000;
	localparam coeff_row_t ROW_W_RESET = 64'h1000_0000_0000_0000;

	// Classification of one box.
	typedef enum logic [1:0] {
		CLIP_INSIDE  = 2'd0,
		CLIP_CLIPPED = 2'd1,
		CLIP_OUTSIDE = 2'd2
	} clip_result_t;

endpackage

// ===== rtl/core/afc_xform.sv =====
// First pipeline stage: coefficient-by-coordinate products for both box extents.
// Depends on afc_pkg.
module afc_xform #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    up_valid,
	output logic                    up_ready,
	input  logic signed [COORD_BITS-1:0] lo_coord [afc_pkg::NUM_AXES],
	input  logic signed [COORD_BITS-1:0] hi_coord [afc_pkg::NUM_AXES],
	input  afc_pkg::coeff_row_t     coeff_rows [afc_pkg::NUM_ROWS],
	output logic                    valid_s1,
	input  logic                    down_ready,
	output logic signed [COORD_BITS+afc_pkg::LANE_BITS-1:0]
		prod_s1 [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES][2],
	output logic signed [afc_pkg::LANE_BITS-1:0] const_s1 [afc_pkg::NUM_ROWS]
);
	import afc_pkg::*;

	localparam int PW = COORD_BITS + LANE_BITS;

	logic ready_s1;

	// The stage takes a word when it is empty or its word moves on.
	assign ready_s1 = !valid_s1 || down_ready;
	assign up_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= up_valid;
		end
	end

	// One product per row, axis and extent; the constant lane rides along.
	always_ff @(posedge clk) begin
		if (up_valid && ready_s1) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					prod_s1[r][a][0] <= PW'($signed(coeff_rows[r][a]) * lo_coord[a]);
					prod_s1[r][a][1] <= PW'($signed(coeff_rows[r][a]) * hi_coord[a]);
				end
				const_s1[r] <= coeff_rows[r][LANE_CONST];
			end
		end
	end

endmodule

// ===== rtl/core/afc_sum.sv =====
// Second and third pipeline stages: adds the products into the four clip
// components of all eight corners. Depends on afc_pkg.
module afc_sum #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  logic signed [COORD_BITS+afc_pkg::LANE_BITS-1:0]
		prod_s1 [afc_pkg::NUM_ROWS][afc_pkg::NUM_AXES][2],
	input  logic signed [afc_pkg::LANE_BITS-1:0] const_s1 [afc_pkg::NUM_ROWS],
	output logic valid_s3,
	input  logic down_ready,
	output logic signed [COORD_BITS+afc_pkg::LANE_BITS+1:0]
		dot_s3 [afc_pkg::NUM_ROWS][afc_pkg::NUM_CORNERS]
);
	import afc_pkg::*;

	localparam int PW = COORD_BITS + LANE_BITS;
	localparam int SW = PW + 1;

	logic valid_s2;
	logic ready_s2;
	logic ready_s3;
	logic signed [SW-1:0] pxy_s2 [NUM_ROWS][4];
	logic signed [SW-1:0] pzc_s2 [NUM_ROWS][2];

	assign ready_s3 = !valid_s3 || down_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= up_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Partial sums: x plus y for the four xy combinations, z plus the constant
	// for both z extents.
	always_ff @(posedge clk) begin
		if (up_valid && ready_s2) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int k = 0; k < 4; k++) begin
					pxy_s2[r][k] <= {prod_s1[r][LANE_X][k[0]][PW-1], prod_s1[r][LANE_X][k[0]]}
						+ {prod_s1[r][LANE_Y][k[1]][PW-1], prod_s1[r][LANE_Y][k[1]]};
				end
				for (int s = 0; s < 2; s++) begin
					pzc_s2[r][s] <= {prod_s1[r][LANE_Z][s][PW-1], prod_s1[r][LANE_Z][s]}
						+ {{(SW-LANE_BITS){const_s1[r][LANE_BITS-1]}}, const_s1[r]};
				end
			end
		end
	end

	// Full clip component per corner: corner bit 0 picks x, bit 1 y, bit 2 z.
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				for (int c = 0; c < NUM_CORNERS; c++) begin
					dot_s3[r][c] <= {pxy_s2[r][c[1:0]][SW-1], pxy_s2[r][c[1:0]]}
						+ {pzc_s2[r][c[2]][SW-1], pzc_s2[r][c[2]]};
				end
			end
		end
	end

endmodule

// ===== rtl/core/afc_classify.sv =====
// Last pipeline stage: corner outcodes against w, their OR and AND, and the
// classification; holds the output word. Depends on afc_pkg.
module afc_classify #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  logic signed [COORD_BITS+afc_pkg::LANE_BITS+1:0]
		dot_s3 [afc_pkg::NUM_ROWS][afc_pkg::NUM_CORNERS],
	output logic valid_s4,
	input  logic down_ready,
	output afc_pkg::clip_result_t result_s4,
	output logic [afc_pkg::OUTCODE_BITS-1:0] or_code_s4
);
	import afc_pkg::*;

	localparam int DW = COORD_BITS + LANE_BITS + 2;
	localparam int EW = DW + 1;

	logic ready_s4;
	logic [OUTCODE_BITS-1:0] code [NUM_CORNERS];
	logic [OUTCODE_BITS-1:0] or_code;
	logic [OUTCODE_BITS-1:0] and_code;
	clip_result_t result;

	assign ready_s4 = !valid_s4 || down_ready;
	assign up_ready = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= up_valid;
		end
	end

	// Per corner and axis only one side is flagged: below -w first, else above w.
	// One extra bit keeps -w exact.
	always_comb begin
		logic signed [EW-1:0] v_e;
		logic signed [EW-1:0] w_e;
		for (int c = 0; c < NUM_CORNERS; c++) begin
			code[c] = '0;
			w_e = {dot_s3[ROW_W][c][DW-1], dot_s3[ROW_W][c]};
			for (int a = 0; a < NUM_AXES; a++) begin
				v_e = {dot_s3[a][c][DW-1], dot_s3[a][c]};
				if (v_e < -w_e) begin
					code[c][2*a] = 1'b1;
				end else if (v_e > w_e) begin
					code[c][2*a+1] = 1'b1;
				end
			end
		end
	end

	// Reduce the eight outcodes and classify the box.
	always_comb begin
		or_code  = '0;
		and_code = '1;
		for (int c = 0; c < NUM_CORNERS; c++) begin
			or_code  = or_code | code[c];
			and_code = and_code & code[c];
		end
		if (or_code == '0) begin
			result = CLIP_INSIDE;
		end else if (and_code != '0) begin
			result = CLIP_OUTSIDE;
		end else begin
			result = CLIP_CLIPPED;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && ready_s4) begin
			result_s4  <= result;
			or_code_s4 <= or_code;
		end
	end

endmodule

// ===== rtl/core/aabb_frustum_clip_status.sv =====
// Top level of the box frustum clip status pipeline: configuration registers
// and the four pipeline stages. Depends on afc_pkg, afc_xform, afc_sum, afc_classify.
//
//   channel  | handshake              | word
//   ---------+------------------------+-------------------------------------
//   input    | in_valid / in_stall    | box_min_x..z, box_max_x..z
//   output   | out_valid / out_stall  | clip_result, any_outcode
//   config   | cfg_wr_en              | cfg_index, cfg_data (64-bit row)
//
// A box passes four register stages: multiply, two adder stages, then compare
// and reduce into the output register. One box is accepted per cycle when the
// output is taken every cycle. Each stage has its own valid bit and fills any
// bubble ahead of it, so a stalled output holds only the last stage and input
// words keep entering until the pipeline is full. Reset clears the valid bits
// and loads the identity matrix into the coefficient registers.
module aabb_frustum_clip_status #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [afc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [afc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [COORD_BITS-1:0] box_min_x,
	input  logic signed [COORD_BITS-1:0] box_min_y,
	input  logic signed [COORD_BITS-1:0] box_min_z,
	input  logic signed [COORD_BITS-1:0] box_max_x,
	input  logic signed [COORD_BITS-1:0] box_max_y,
	input  logic signed [COORD_BITS-1:0] box_max_z,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] clip_result,
	output logic [afc_pkg::OUTCODE_BITS-1:0] any_outcode
);
	import afc_pkg::*;

	localparam int PW = COORD_BITS + LANE_BITS;
	localparam int DW = PW + 2;

	coeff_row_t rows_q [NUM_ROWS];

	logic signed [COORD_BITS-1:0] lo_coord [NUM_AXES];
	logic signed [COORD_BITS-1:0] hi_coord [NUM_AXES];

	logic in_ready;
	logic valid_s1;
	logic ready_sum;
	logic valid_s3;
	logic ready_cls;
	logic valid_s4;
	logic signed [PW-1:0] prod_s1 [NUM_ROWS][NUM_AXES][2];
	logic signed [LANE_BITS-1:0] const_s1 [NUM_ROWS];
	logic signed [DW-1:0] dot_s3 [NUM_ROWS][NUM_CORNERS];
	clip_result_t result_s4;
	logic [OUTCODE_BITS-1:0] or_code_s4;

	// Coefficient rows; the user must write them only while the pipeline is empty; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q[ROW_X] <= ROW_X_RESET;
			rows_q[ROW_Y] <= ROW_Y_RESET;
			rows_q[ROW_Z] <= ROW_Z_RESET;
			rows_q[ROW_W] <= ROW_W_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CLIP_X: rows_q[ROW_X] <= cfg_data;
				CFG_CLIP_Y: rows_q[ROW_Y] <= cfg_data;
				CFG_CLIP_Z: rows_q[ROW_Z] <= cfg_data;
				CFG_CLIP_W: rows_q[ROW_W] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lo_coord[0] = box_min_x;
	assign lo_coord[1] = box_min_y;
	assign lo_coord[2] = box_min_z;
	assign hi_coord[0] = box_max_x;
	assign hi_coord[1] = box_max_y;
	assign hi_coord[2] = box_max_z;

	assign in_stall = !in_ready;

	afc_xform #(
		.COORD_BITS(COORD_BITS)
	) u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (in_valid),
		.up_ready   (in_ready),
		.lo_coord   (lo_coord),
		.hi_coord   (hi_coord),
		.coeff_rows (rows_q),
		.valid_s1   (valid_s1),
		.down_ready (ready_sum),
		.prod_s1    (prod_s1),
		.const_s1   (const_s1)
	);

	afc_sum #(
		.COORD_BITS(COORD_BITS)
	) u_sum (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s1),
		.up_ready   (ready_sum),
		.prod_s1    (prod_s1),
		.const_s1   (const_s1),
		.valid_s3   (valid_s3),
		.down_ready (ready_cls),
		.dot_s3     (dot_s3)
	);

	afc_classify #(
		.COORD_BITS(COORD_BITS)
	) u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (valid_s3),
		.up_ready   (ready_cls),
		.dot_s3     (dot_s3),
		.valid_s4   (valid_s4),
		.down_ready (!out_stall),
		.result_s4  (result_s4),
		.or_code_s4 (or_code_s4)
	);

	assign out_valid   = valid_s4;
	assign clip_result = result_s4;
	assign any_outcode = or_code_s4;

endmodule

// ===== tb/afc_checker.sv =====
// Checker for the box frustum clip status block: follows the config port,
// predicts one result word per accepted box word and compares in order.
// Depends on afc_pkg for the row type, lane order and register indexes.
module afc_checker #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [afc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [afc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [COORD_BITS-1:0] box_min_x,
	input  logic signed [COORD_BITS-1:0] box_min_y,
	input  logic signed [COORD_BITS-1:0] box_min_z,
	input  logic signed [COORD_BITS-1:0] box_max_x,
	input  logic signed [COORD_BITS-1:0] box_max_y,
	input  logic signed [COORD_BITS-1:0] box_max_z,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [1:0] clip_result,
	input  logic [afc_pkg::OUTCODE_BITS-1:0] any_outcode,
	output int error_count,
	output int pending
);
	import afc_pkg::*;

	typedef struct {
		clip_result_t result;
		logic [OUTCODE_BITS-1:0] outcode;
	} box_status_t;

	coeff_row_t row_x, row_y, row_z, row_w;
	box_status_t status_q[$];

	// One signed Q4.12 lane of a row, widened.
	function automatic longint lane_of(coeff_row_t r, int lane);
		logic signed [LANE_BITS-1:0] v;
		v = r[lane];
		return longint'(v);
	endfunction

	// One clip-space component in units of 2^-12, kept at full width.
	function automatic longint project(coeff_row_t r, longint x, longint y, longint z);
		return lane_of(r, LANE_X) * x + lane_of(r, LANE_Y) * y
			+ lane_of(r, LANE_Z) * z + lane_of(r, LANE_CONST);
	endfunction

	// Low side wins over high side; equality with the plane flags nothing.
	function automatic logic [1:0] plane_bits(longint v, longint w);
		if (v < -w)
			return 2'b01;
		if (v > w)
			return 2'b10;
		return 2'b00;
	endfunction

	// Transform all eight corners, then reduce their outcodes.
	function automatic box_status_t classify_box(longint lo_x, longint lo_y, longint lo_z,
			longint hi_x, longint hi_y, longint hi_z);
		box_status_t s;
		logic [OUTCODE_BITS-1:0] any_code, all_code, code;
		longint x, y, z, cx, cy, cz, cw;
		any_code = '0;
		all_code = '1;
		for (int c = 0; c < NUM_CORNERS; c++) begin
			x = c[0] ? hi_x : lo_x;
			y = c[1] ? hi_y : lo_y;
			z = c[2] ? hi_z : lo_z;
			cx = project(row_x, x, y, z);
			cy = project(row_y, x, y, z);
			cz = project(row_z, x, y, z);
			cw = project(row_w, x, y, z);
			code = {plane_bits(cz, cw), plane_bits(cy, cw), plane_bits(cx, cw)};
			any_code |= code;
			all_code &= code;
		end
		s.outcode = any_code;
		if (any_code == '0)
			s.result = CLIP_INSIDE;
		else if (all_code != '0)
			s.result = CLIP_OUTSIDE;
		else
			s.result = CLIP_CLIPPED;
		return s;
	endfunction

	// Compare results, predict new boxes, then follow register writes.
	always @(posedge clk or negedge arst_n) begin
		box_status_t want;
		if (!arst_n) begin
			row_x = ROW_X_RESET;
			row_y = ROW_Y_RESET;
			row_z = ROW_Z_RESET;
			row_w = ROW_W_RESET;
			status_q.delete();
			error_count = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					$display("%0t: unexpected result word, %s %0d any_outcode %02h",
						$time, "actual clip_result", clip_result, any_outcode);
					error_count++;
				end else begin
					want = status_q.pop_front();
					if (clip_result !== want.result) begin
						$display("%0t: clip_result expected %0d actual %0d",
							$time, want.result, clip_result);
						error_count++;
					end
					if (any_outcode !== want.outcode) begin
						$display("%0t: any_outcode expected %02h actual %02h",
							$time, want.outcode, any_outcode);
						error_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				status_q.push_back(classify_box(box_min_x, box_min_y, box_min_z,
					box_max_x, box_max_y, box_max_z));
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CLIP_X: row_x = cfg_data;
					CFG_CLIP_Y: row_y = cfg_data;
					CFG_CLIP_Z: row_z = cfg_data;
					CFG_CLIP_W: row_w = cfg_data;
					default: ;
				endcase
			end
			pending = status_q.size();
		end
	end

endmodule

// ===== tb/aabb_frustum_clip_status_tb.sv =====
// Testbench top for aabb_frustum_clip_status: directed and random box words
// under several matrices, with random gaps on both channels.
// Depends on afc_pkg, the block itself and afc_checker.
module aabb_frustum_clip_status_tb;
	import afc_pkg::*;

	localparam int COORD_BITS = 16;
	localparam int PHASES = 8;
	localparam int BOXES_PER_PHASE = 125;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef struct packed {
		coord_t min_x, min_y, min_z, max_x, max_y, max_z;
	} box_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic in_valid;
	logic in_stall;
	coord_t box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z;
	logic out_valid;
	logic out_stall;
	logic [1:0] clip_result;
	logic [OUTCODE_BITS-1:0] any_outcode;
	int error_count;
	int pending;
	int burst_left;

	aabb_frustum_clip_status #(.COORD_BITS(COORD_BITS)) dut (.*);

	afc_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Generous bound on the whole run.
	initial begin
		#10_000_000;
		$display("aabb_frustum_clip_status_tb: errors");
		$finish;
	end

	function automatic box_t mk_box(int a, int b, int c, int d, int e, int f);
		box_t bx;
		bx.min_x = coord_t'(a);
		bx.min_y = coord_t'(b);
		bx.min_z = coord_t'(c);
		bx.max_x = coord_t'(d);
		bx.max_y = coord_t'(e);
		bx.max_z = coord_t'(f);
		return bx;
	endfunction

	function automatic coord_t clamp_coord(int v);
		if (v > 32767)
			return coord_t'(32767);
		if (v < -32768)
			return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	function automatic logic [LANE_BITS-1:0] small_lane(int span);
		return LANE_BITS'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Mostly boxes at one of several scales around a random center; some are
	// fully random words, and some axes have min above max.
	function automatic box_t random_box();
		int lo[3], hi[3];
		int r, c, h, t;
		box_t bx;
		if ($urandom_range(0, 4) == 0)
			return box_t'({$urandom, $urandom, $urandom});
		case ($urandom_range(0, 3))
			0: r = 3;
			1: r = 60;
			2: r = 1000;
			default: r = 30000;
		endcase
		for (int a = 0; a < NUM_AXES; a++) begin
			c = int'($urandom_range(0, 2 * r)) - r;
			h = $urandom_range(0, r);
			lo[a] = c - h;
			hi[a] = c + h;
			if ($urandom_range(0, 9) == 0) begin
				t = lo[a];
				lo[a] = hi[a];
				hi[a] = t;
			end
		end
		bx.min_x = clamp_coord(lo[0]);
		bx.min_y = clamp_coord(lo[1]);
		bx.min_z = clamp_coord(lo[2]);
		bx.max_x = clamp_coord(hi[0]);
		bx.max_y = clamp_coord(hi[1]);
		bx.max_z = clamp_coord(hi[2]);
		return bx;
	endfunction

	// A projection-like row: a scaled main term, small tilts and an offset.
	function automatic coeff_row_t diag_row(int main_lane);
		coeff_row_t r;
		int scale;
		r = '0;
		for (int l = 0; l < NUM_AXES; l++)
			if ($urandom_range(0, 1))
				r[l] = small_lane(16'h0100);
		scale = $urandom_range(1, 16'h2000);
		if ($urandom_range(0, 3) == 0)
			scale = -scale;
		r[main_lane] = LANE_BITS'(scale);
		r[LANE_CONST] = small_lane(16'h1000);
		return r;
	endfunction

	// Present one box word, hold it until taken, then maybe leave a gap.
	task automatic send_box(input box_t bx);
		int gap, pick;
		in_valid <= 1'b1;
		box_min_x <= bx.min_x;
		box_min_y <= bx.min_y;
		box_min_z <= bx.min_z;
		box_max_x <= bx.max_x;
		box_max_y <= bx.max_y;
		box_max_z <= bx.max_z;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				burst_left = $urandom_range(20, 80);
				gap = 0;
			end else if (pick < 55)
				gap = 0;
			else if (pick < 88)
				gap = $urandom_range(1, 3);
			else if (pick < 97)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap > 0) begin
			// Idle bus carries junk that must be ignored.
			in_valid <= 1'b0;
			{box_min_x, box_min_y, box_min_z} <= (3 * COORD_BITS)'({$urandom, $urandom});
			{box_max_x, box_max_y, box_max_z} <= (3 * COORD_BITS)'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and let every expected word come out, then idle before returning.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_matrix(input coeff_row_t rx, input coeff_row_t ry,
			input coeff_row_t rz, input coeff_row_t rw);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_CLIP_X;
		cfg_data <= rx;
		@(posedge clk);
		cfg_index <= CFG_CLIP_Y;
		cfg_data <= ry;
		@(posedge clk);
		cfg_index <= CFG_CLIP_Z;
		cfg_data <= rz;
		@(posedge clk);
		cfg_index <= CFG_CLIP_W;
		cfg_data <= rw;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: stretches of free flow broken by stalls of random length.
	initial begin : stall_gen
		int pick, len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				out_stall <= 1'b0;
				len = (pick < 60) ? $urandom_range(1, 12) : $urandom_range(50, 200);
			end else begin
				out_stall <= 1'b1;
				len = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		coeff_row_t rw, r_ones, r_min, r_max;
		box_t extreme;
		burst_left = 0;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= CFG_CLIP_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		{box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z} <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity matrix from reset: planes sit at +-1 in box units.
		extreme = mk_box(-32768, -32768, -32768, 32767, 32767, 32767);
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		// A corner exactly on the far-right plane and on the near-left plane.
		send_box(mk_box(1, 1, 1, 1, 1, 1));
		send_box(mk_box(-1, -1, -1, -1, -1, -1));
		send_box(mk_box(2, 2, 2, 2, 2, 2));
		send_box(mk_box(-2, -2, -2, -2, -2, -2));
		send_box(mk_box(-2, -2, -2, 2, 2, 2));
		// Minimum above maximum behaves as the swapped box.
		send_box(mk_box(2, 2, 2, -2, -2, -2));
		send_box(extreme);
		send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
		send_box(mk_box(0, -1, 0, 5, 1, 0));
		send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
		drain();

		// Zero w: only the sign of each component decides.
		load_matrix(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET, '0);
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(1, 1, 1, 1, 1, 1));
		send_box(mk_box(-1, -1, -1, 1, 1, 1));
		drain();

		// Negative w: both sides of each axis overlap, so every corner flags.
		rw = '0;
		rw[LANE_CONST] = 16'h8000;
		load_matrix(ROW_X_RESET, ROW_Y_RESET, ROW_Z_RESET, rw);
		send_box(mk_box(0, 0, 0, 0, 0, 0));
		send_box(mk_box(-3, -3, -3, 3, 3, 3));
		drain();

		// All-ones, minimum, maximum and zero coefficient values in every lane of every row.
		r_ones = '1;
		r_min = {NUM_LANES{16'h8000}};
		r_max = {NUM_LANES{16'h7fff}};
		load_matrix(r_ones, r_ones, r_ones, r_ones);
		send_box(extreme);
		send_box(mk_box(-1, 0, 1, 1, 0, -1));
		drain();
		load_matrix(r_min, r_min, r_min, r_min);
		send_box(extreme);
		send_box(mk_box(-1, 0, 1, 1, 0, -1));
		drain();
		load_matrix(r_max, r_max, r_max, r_max);
		send_box(extreme);
		send_box(mk_box(-1, 0, 1, 1, 0, -1));
		drain();
		load_matrix('0, '0, '0, '0);
		send_box(extreme);
		send_box(mk_box(-1, 0, 1, 1, 0, -1));
		drain();

		// Random phases, mostly under projection-like matrices.
		for (int p = 0; p < PHASES; p++) begin
			if (p % 3 == 2) begin
				load_matrix({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			end else begin
				rw = '0;
				rw[LANE_CONST] = LANE_BITS'($urandom_range(16'h0100, 16'h7fff));
				if ($urandom_range(0, 1))
					rw[LANE_Z] = small_lane(64);
				load_matrix(diag_row(LANE_X), diag_row(LANE_Y), diag_row(LANE_Z), rw);
			end
			for (int i = 0; i < BOXES_PER_PHASE; i++)
				send_box(random_box());
			drain();
		end

		if (error_count == 0 && pending == 0)
			$display("aabb_frustum_clip_status_tb: clean");
		else
			$display("aabb_frustum_clip_status_tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/afc_pkg.sv
rtl/core/afc_xform.sv
rtl/core/afc_sum.sv
rtl/core/afc_classify.sv
rtl/core/aabb_frustum_clip_status.sv
tb/afc_checker.sv
tb/aabb_frustum_clip_status_tb.sv
